[hw/rtl/tcl_pkg.sv]
// Shared types and codes for the LRU tile cache with a byte budget.
`timescale 1ns / 1ps
`default_nettype none
package tcl_pkg;

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_GET   = 2'd1;
   localparam logic [1:0] REQ_PURGE = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISS    = 2'd1;
   localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  map_id;
      logic [15:0] tile_x;
      logic [15:0] tile_y;
      logic [12:0] tile_width;
      logic [12:0] tile_height;
      logic [5:0]  pixel_bits;
      logic [31:0] buffer_handle;
   } tcl_req_type;

   typedef struct packed {
      logic [7:0]  map_id;
      logic [15:0] x;
      logic [15:0] y;
      logic [12:0] w;
      logic [12:0] h;
      logic [5:0]  bits;
      logic [31:0] handle;
      logic [31:0] cost;
   } tcl_entry_type;

   typedef struct packed {
      logic          wr_en;
      tcl_entry_type wr_data;
   } tcl_mem_ctl_type;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_MUL    = 12'b0000_0000_0010,
      ST_CHECK  = 12'b0000_0000_0100,
      ST_EVAL   = 12'b0000_0000_1000,
      ST_FIND   = 12'b0000_0001_0000,
      ST_RDCOST = 12'b0000_0010_0000,
      ST_SUBC   = 12'b0000_0100_0000,
      ST_FREE   = 12'b0000_1000_0000,
      ST_WRITE  = 12'b0001_0000_0000,
      ST_GSCAN  = 12'b0010_0000_0000,
      ST_GHIT   = 12'b0100_0000_0000,
      ST_RESP   = 12'b1000_0000_0000
   } tcl_state_type;

endpackage
`default_nettype wire

[hw/rtl/tcl_ifs.sv]
// Handshake channel interfaces for requests, results and the budget register.
`timescale 1ns / 1ps
`default_nettype none
interface tcl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  map_id;
   logic [15:0] tile_x;
   logic [15:0] tile_y;
   logic [12:0] tile_width;
   logic [12:0] tile_height;
   logic [5:0]  pixel_bits;
   logic [31:0] buffer_handle;
   modport source (output valid, req_type, map_id, tile_x, tile_y, tile_width,
                   tile_height, pixel_bits, buffer_handle, input ready);
   modport sink (input valid, req_type, map_id, tile_x, tile_y, tile_width,
                 tile_height, pixel_bits, buffer_handle, output ready);
endinterface

interface tcl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  hit_map_id;
   logic [15:0] hit_x;
   logic [15:0] hit_y;
   logic [12:0] hit_width;
   logic [12:0] hit_height;
   logic [5:0]  hit_bits;
   logic [31:0] hit_handle;
   logic [31:0] bytes_in_use;
   modport source (output valid, status, hit_map_id, hit_x, hit_y, hit_width,
                   hit_height, hit_bits, hit_handle, bytes_in_use, input ready);
   modport sink (input valid, status, hit_map_id, hit_x, hit_y, hit_width,
                 hit_height, hit_bits, hit_handle, bytes_in_use, output ready);
endinterface

interface tcl_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] byte_budget;
   modport source (output valid, byte_budget, input ready);
   modport sink (input valid, byte_budget, output ready);
endinterface
`default_nettype wire

[hw/rtl/tile_cache_lru_byte_budget.sv]
// Top level of the LRU tile cache with a byte budget and its sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Tile cache that keeps up to NUM_SLOTS pixel tiles in recency order under a
// byte budget written through the csr channel. Each request beat is an add,
// a get or a purge, and each produces exactly one result beat. An add first
// computes the tile cost (width times height times bits, divided by eight,
// plus ENTRY_OVERHEAD) in a two-stage multiplier, then evicts least recent
// entries until the tile fits and a slot is free, then takes the lowest
// free slot. A get scans every slot through the single read port of the
// slot memory, one slot per cycle, and keeps the most recent containing
// match. The block handles one request at a time and is not ready while
// it works. Each eviction searches the recency ranks one slot per cycle
// and then reads the victim's cost from memory. A finished result sits in
// an output register; the next request may be accepted while it waits,
// and its own result waits until that register is free. An add whose
// cost exceeds the whole budget is refused as too big.
module tile_cache_lru_byte_budget
   import tcl_pkg::*;
#(
   parameter int NUM_SLOTS      = 16,
   parameter int ENTRY_OVERHEAD = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   tcl_req_if.sink   req_chan,
   tcl_rsp_if.source rsp_chan,
   tcl_csr_if.sink   csr_chan
);

   localparam int AW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(NUM_SLOTS);

   tcl_state_type state_ff, state_in;

   logic [31:0]          budget_ff, budget_in;
   logic [31:0]          used_ff, used_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [AW-1:0]        age_ff [NUM_SLOTS];
   logic [AW-1:0]        age_in [NUM_SLOTS];
   logic [CW-1:0]        count_ff, count_in;

   tcl_req_type   req_ff, req_in;
   logic [31:0]   cost_ff, cost_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic [AW-1:0] victim_ff, victim_in;
   logic          full_ff, full_in;
   logic          found_ff, found_in;
   logic [AW-1:0] best_ff, best_in;
   logic [AW-1:0] best_age_ff, best_age_in;
   tcl_entry_type best_ent_ff, best_ent_in;
   logic [1:0]    status_ff, status_in;
   logic          hit_ff, hit_in;

   logic          rsp_vld_ff, rsp_vld_in;
   logic [1:0]    o_status_ff, o_status_in;
   tcl_entry_type o_ent_ff, o_ent_in;
   logic [31:0]   o_bytes_ff, o_bytes_in;

   logic            cost_start, cost_done;
   logic [31:0]     cost_out;
   tcl_mem_ctl_type mem_ctl;
   logic [AW-1:0]   rd_addr;
   tcl_entry_type   rd_data;

   logic [AW-1:0] scan_idx;
   logic          over_budget;
   logic          match;
   logic [16:0]   ent_right, ent_bottom, req_right, req_bottom;

   tcl_cost_unit #(.ENTRY_OVERHEAD(ENTRY_OVERHEAD)) u_cost (
      .clock       (clock),
      .reset       (reset),
      .start       (cost_start),
      .tile_width  (req_ff.tile_width),
      .tile_height (req_ff.tile_height),
      .pixel_bits  (req_ff.pixel_bits),
      .done        (cost_done),
      .cost        (cost_out)
   );

   tcl_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (victim_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign scan_idx = scan_ff[AW-1:0];
   assign rd_addr  = (state_ff == ST_RDCOST) ? victim_ff : scan_idx;

   // The budget test is done one bit wider so that the sum cannot wrap.
   assign over_budget = ({1'b0, used_ff} + {1'b0, cost_ff}) > {1'b0, budget_ff};

   // Containment test of the request rectangle against the slot just read.
   assign ent_right  = {1'b0, rd_data.x} + 17'(rd_data.w);
   assign ent_bottom = {1'b0, rd_data.y} + 17'(rd_data.h);
   assign req_right  = {1'b0, req_ff.tile_x} + 17'(req_ff.tile_width);
   assign req_bottom = {1'b0, req_ff.tile_y} + 17'(req_ff.tile_height);
   assign match = valid_ff[pidx_ff] && (rd_data.map_id == req_ff.map_id)
                  && (rd_data.x <= req_ff.tile_x) && (rd_data.y <= req_ff.tile_y)
                  && (ent_right >= req_right) && (ent_bottom >= req_bottom)
                  && ((req_ff.pixel_bits == 6'd0) || (rd_data.bits == req_ff.pixel_bits))
                  && (!found_ff || (age_ff[pidx_ff] < best_age_ff));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   always_comb begin
      state_in    = state_ff;
      budget_in   = budget_ff;
      used_in     = used_ff;
      valid_in    = valid_ff;
      age_in      = age_ff;
      count_in    = count_ff;
      req_in      = req_ff;
      cost_in     = cost_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pidx_in     = pidx_ff;
      victim_in   = victim_ff;
      full_in     = full_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_age_in = best_age_ff;
      best_ent_in = best_ent_ff;
      status_in   = status_ff;
      hit_in      = hit_ff;
      rsp_vld_in  = rsp_vld_ff;
      o_status_in = o_status_ff;
      o_ent_in    = o_ent_ff;
      o_bytes_in  = o_bytes_ff;
      cost_start  = 1'b0;
      mem_ctl.wr_en   = 1'b0;
      mem_ctl.wr_data = '{map_id: req_ff.map_id, x: req_ff.tile_x, y: req_ff.tile_y,
                          w: req_ff.tile_width, h: req_ff.tile_height,
                          bits: req_ff.pixel_bits, handle: req_ff.buffer_handle,
                          cost: cost_ff};

      if (csr_chan.valid) begin
         budget_in = csr_chan.byte_budget;
      end
      if (rsp_vld_ff && rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               req_in = '{req_type: req_chan.req_type, map_id: req_chan.map_id,
                          tile_x: req_chan.tile_x, tile_y: req_chan.tile_y,
                          tile_width: req_chan.tile_width,
                          tile_height: req_chan.tile_height,
                          pixel_bits: req_chan.pixel_bits,
                          buffer_handle: req_chan.buffer_handle};
               status_in = STATUS_OK;
               hit_in    = 1'b0;
               scan_in   = '0;
               pend_in   = 1'b0;
               found_in  = 1'b0;
               priority if (req_chan.req_type == REQ_ADD) begin
                  state_in = ST_MUL;
               end else if (req_chan.req_type == REQ_GET) begin
                  state_in = ST_GSCAN;
               end else if (req_chan.req_type == REQ_PURGE) begin
                  valid_in = '0;
                  count_in = '0;
                  used_in  = '0;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_MUL: begin
            cost_start = (req_ff.req_type == REQ_ADD) && !pend_ff;
            pend_in    = 1'b1;
            if (cost_done) begin
               cost_in  = cost_out;
               pend_in  = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cost_ff > budget_ff) begin
               status_in = STATUS_TOO_BIG;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            scan_in = '0;
            priority if (over_budget && (count_ff != '0)) begin
               full_in  = 1'b0;
               state_in = ST_FIND;
            end else if (count_ff == SLOTS_C) begin
               full_in  = 1'b1;
               state_in = ST_FIND;
            end else begin
               state_in = ST_FREE;
            end
         end
         ST_FIND: begin
            // The least recent valid slot holds the rank count minus one.
            if (valid_ff[scan_idx] && (age_ff[scan_idx] == AW'(count_ff - 1'b1))) begin
               victim_in = scan_idx;
               state_in  = ST_RDCOST;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_RDCOST: begin
            state_in = ST_SUBC;
         end
         ST_SUBC: begin
            used_in             = used_ff - rd_data.cost;
            valid_in[victim_ff] = 1'b0;
            count_in            = count_ff - 1'b1;
            scan_in             = '0;
            state_in            = full_ff ? ST_FREE : ST_EVAL;
         end
         ST_FREE: begin
            if (!valid_ff[scan_idx]) begin
               victim_in = scan_idx;
               state_in  = ST_WRITE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            mem_ctl.wr_en = 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (valid_ff[i]) begin
                  age_in[i] = age_ff[i] + 1'b1;
               end
            end
            age_in[victim_ff]   = '0;
            valid_in[victim_ff] = 1'b1;
            count_in            = count_ff + 1'b1;
            used_in             = used_ff + cost_ff;
            state_in            = ST_RESP;
         end
         ST_GSCAN: begin
            // The slot is judged in the cycle after its address goes out.
            if (pend_ff && match) begin
               found_in    = 1'b1;
               best_in     = pidx_ff;
               best_age_in = age_ff[pidx_ff];
               best_ent_in = rd_data;
            end
            if (scan_ff != SLOTS_C) begin
               pidx_in = scan_idx;
               pend_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_GHIT;
               end
            end
         end
         ST_GHIT: begin
            if (found_ff) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (valid_ff[i] && (age_ff[i] < best_age_ff)) begin
                     age_in[i] = age_ff[i] + 1'b1;
                  end
               end
               age_in[best_ff] = '0;
               hit_in          = 1'b1;
               status_in       = STATUS_OK;
            end else begin
               status_in = STATUS_MISS;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in  = 1'b1;
               o_status_in = status_ff;
               o_ent_in    = hit_ff ? best_ent_ff : '0;
               o_bytes_in  = used_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      cost_ff     <= cost_in;
      pidx_ff     <= pidx_in;
      victim_ff   <= victim_in;
      full_ff     <= full_in;
      best_ff     <= best_in;
      best_age_ff <= best_age_in;
      best_ent_ff <= best_ent_in;
      status_ff   <= status_in;
      hit_ff      <= hit_in;
      o_status_ff <= o_status_in;
      o_ent_ff    <= o_ent_in;
      o_bytes_ff  <= o_bytes_in;
      scan_ff     <= scan_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         budget_ff  <= '0;
         used_ff    <= '0;
         valid_ff   <= '0;
         count_ff   <= '0;
         pend_ff    <= 1'b0;
         found_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         budget_ff  <= budget_in;
         used_ff    <= used_in;
         valid_ff   <= valid_in;
         count_ff   <= count_in;
         pend_ff    <= pend_in;
         found_ff   <= found_in;
         rsp_vld_ff <= rsp_vld_in;
         age_ff     <= age_in;
      end
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.status       = o_status_ff;
   assign rsp_chan.hit_map_id   = o_ent_ff.map_id;
   assign rsp_chan.hit_x        = o_ent_ff.x;
   assign rsp_chan.hit_y        = o_ent_ff.y;
   assign rsp_chan.hit_width    = o_ent_ff.w;
   assign rsp_chan.hit_height   = o_ent_ff.h;
   assign rsp_chan.hit_bits     = o_ent_ff.bits;
   assign rsp_chan.hit_handle   = o_ent_ff.handle;
   assign rsp_chan.bytes_in_use = o_bytes_ff;

   // The occupancy count always tracks the number of valid slots.
   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(count_ff))
      else $error("slot count differs from valid slots");

   // An empty cache accounts for no bytes.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (used_ff == '0))
      else $error("bytes in use without any entry");

   // A new entry is written only when a slot is free.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (count_ff < SLOTS_C) && !valid_ff[victim_ff])
      else $error("tile written into an occupied slot");

endmodule
`default_nettype wire

[hw/rtl/tcl_cost_unit.sv]
// Two-stage multiplier that computes the byte cost of a tile.
`timescale 1ns / 1ps
`default_nettype none
module tcl_cost_unit #(
   parameter int ENTRY_OVERHEAD = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [12:0] tile_width,
   input  wire logic [12:0] tile_height,
   input  wire logic [5:0]  pixel_bits,
   output logic             done,
   output logic [31:0]      cost
);

   logic [25:0] area_ff, area_in;
   logic [5:0]  bits_ff, bits_in;
   logic [31:0] cost_ff, cost_in;
   logic        v1_ff, v2_ff;
   logic [31:0] prod;

   assign area_in = tile_width * tile_height;
   assign bits_in = pixel_bits;
   assign prod    = {6'd0, area_ff} * {26'd0, bits_ff};
   // Divide by eight bits per byte, then add the fixed per-entry overhead.
   assign cost_in = (prod >> 3) + 32'(ENTRY_OVERHEAD);

   always_ff @(posedge clock) begin
      area_ff <= area_in;
      bits_ff <= bits_in;
      cost_ff <= cost_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   assign done = v2_ff;
   assign cost = cost_ff;

endmodule
`default_nettype wire

[hw/rtl/tcl_slot_mem.sv]
// Slot storage memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tcl_slot_mem
   import tcl_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  wire logic                         clock,
   input  wire tcl_mem_ctl_type              ctl,
   input  wire logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
   input  wire logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
   output tcl_entry_type                     rd_data
);

   tcl_entry_type mem [NUM_SLOTS];
   tcl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[tb/tile_cache_lru_byte_budget_tb.sv]
// Testbench for the LRU tile cache: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

// Holds the predicted cache contents and the queue of expected result beats.
class tile_cache_scoreboard;
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  map_id;
      logic [15:0] x;
      logic [15:0] y;
      logic [12:0] w;
      logic [12:0] h;
      logic [5:0]  bits;
      logic [31:0] handle;
      logic [31:0] bytes;
   } tile_result_type;

   bit          valid[16];
   logic [7:0]  map[16];
   logic [15:0] sx[16], sy[16];
   logic [12:0] sw[16], sh[16];
   logic [5:0]  sbits[16];
   logic [31:0] shandle[16], scost[16];
   int unsigned age[16];
   logic [31:0] used;
   logic [31:0] budget;
   tile_result_type pending[$];
   int errors;

   function void clear();
      foreach (valid[i]) begin
         valid[i] = 0;
         age[i] = 0;
      end
      used = 0;
      budget = 0;
      errors = 0;
      pending.delete();
   endfunction

   function bit drop_oldest();
      int victim;
      victim = -1;
      for (int i = 0; i < 16; i++)
         if (valid[i] && (victim < 0 || age[i] > age[victim])) victim = i;
      if (victim < 0) return 0;
      valid[victim] = 0;
      used -= scost[victim];
      return 1;
   endfunction

   function void promote(int s, int unsigned limit);
      for (int i = 0; i < 16; i++)
         if (valid[i] && i != s && age[i] < limit) age[i]++;
      age[s] = 0;
   endfunction

   // Predicts the result of one accepted request and updates the cache image.
   function void note_request(tcl_pkg::tcl_req_type r);
      tile_result_type res;
      logic [63:0] cost;
      int s, best;
      res = '0;
      if (r.req_type == tcl_pkg::REQ_ADD) begin
         cost = 64'(r.tile_width) * 64'(r.tile_height) * 64'(r.pixel_bits) / 8 + 64;
         if (cost > 64'(budget)) res.status = tcl_pkg::STATUS_TOO_BIG;
         else begin
            while (64'(used) + cost > 64'(budget))
               if (!drop_oldest()) break;
            s = -1;
            for (int i = 0; i < 16; i++)
               if (!valid[i] && s < 0) s = i;
            if (s < 0) begin
               void'(drop_oldest());
               for (int i = 0; i < 16; i++)
                  if (!valid[i] && s < 0) s = i;
            end
            map[s] = r.map_id;
            sx[s] = r.tile_x;
            sy[s] = r.tile_y;
            sw[s] = r.tile_width;
            sh[s] = r.tile_height;
            sbits[s] = r.pixel_bits;
            shandle[s] = r.buffer_handle;
            scost[s] = cost[31:0];
            used += cost[31:0];
            promote(s, 32'hFFFF_FFFF);
            valid[s] = 1;
            res.status = tcl_pkg::STATUS_OK;
         end
      end else if (r.req_type == tcl_pkg::REQ_GET) begin
         best = -1;
         for (int i = 0; i < 16; i++) begin
            if (!valid[i] || map[i] != r.map_id) continue;
            if (sx[i] > r.tile_x || sy[i] > r.tile_y) continue;
            if (17'(sx[i]) + sw[i] < 17'(r.tile_x) + r.tile_width ||
                17'(sy[i]) + sh[i] < 17'(r.tile_y) + r.tile_height) continue;
            if (r.pixel_bits != 0 && sbits[i] != r.pixel_bits) continue;
            if (best < 0 || age[i] < age[best]) best = i;
         end
         if (best < 0) res.status = tcl_pkg::STATUS_MISS;
         else begin
            promote(best, age[best]);
            res.status = tcl_pkg::STATUS_OK;
            res.map_id = map[best];
            res.x = sx[best];
            res.y = sy[best];
            res.w = sw[best];
            res.h = sh[best];
            res.bits = sbits[best];
            res.handle = shandle[best];
         end
      end else if (r.req_type == tcl_pkg::REQ_PURGE) begin
         foreach (valid[i]) valid[i] = 0;
         used = 0;
      end
      res.bytes = used;
      pending.push_back(res);
   endfunction

   function void check_result(tile_result_type got);
      tile_result_type want;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result beat %h", got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         errors++;
         if (errors <= 10)
            $display("result mismatch: expected %h, got %h", want, got);
      end
   endfunction
endclass

module tile_cache_lru_byte_budget_tb;
   import tcl_pkg::*;

   logic clock = 0;
   logic reset = 1;
   always #10 clock = ~clock;

   tcl_req_if req_chan();
   tcl_rsp_if rsp_chan();
   tcl_csr_if csr_chan();

   tile_cache_lru_byte_budget u_dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   tile_cache_scoreboard tile_model;
   int unsigned cycle_count = 0;
   int unsigned hold_cycles = 0;   // receiver hold-off counter for the long stall
   bit stall_pattern_on = 1;
   tcl_req_type recent_adds[$];    // added tiles, reused to build likely hits

   initial begin
      tile_model = new();
      tile_model.clear();
      req_chan.valid = 0;
      req_chan.req_type = REQ_ADD;
      req_chan.map_id = 0;
      req_chan.tile_x = 0;
      req_chan.tile_y = 0;
      req_chan.tile_width = 0;
      req_chan.tile_height = 0;
      req_chan.pixel_bits = 0;
      req_chan.buffer_handle = 0;
      rsp_chan.ready = 0;
      csr_chan.valid = 0;
      csr_chan.byte_budget = 0;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4000000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver: random stall pattern, with an optional long hold-off on top.
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_chan.ready <= 0;
      end else if (!stall_pattern_on) rsp_chan.ready <= 1;
      else rsp_chan.ready <= (cycle_count % 11 < 7) ? ($urandom_range(0, 3) != 0)
                                                    : ($urandom_range(0, 1) != 0);
   end

   // Result monitor: every accepted beat goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tile_model.check_result({rsp_chan.status, rsp_chan.hit_map_id, rsp_chan.hit_x,
                                  rsp_chan.hit_y, rsp_chan.hit_width, rsp_chan.hit_height,
                                  rsp_chan.hit_bits, rsp_chan.hit_handle,
                                  rsp_chan.bytes_in_use});
   end

   // Writes the budget register; the block must be idle beforehand.
   task automatic write_budget(logic [31:0] value);
      csr_chan.valid <= 1;
      csr_chan.byte_budget <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 0;
      tile_model.budget = value;
   endtask

   // Offers one request beat and notes it with the scoreboard once accepted.
   task automatic send_request(tcl_req_type r);
      req_chan.valid <= 1;
      req_chan.req_type <= r.req_type;
      req_chan.map_id <= r.map_id;
      req_chan.tile_x <= r.tile_x;
      req_chan.tile_y <= r.tile_y;
      req_chan.tile_width <= r.tile_width;
      req_chan.tile_height <= r.tile_height;
      req_chan.pixel_bits <= r.pixel_bits;
      req_chan.buffer_handle <= r.buffer_handle;
      do @(posedge clock); while (!req_chan.ready);
      tile_model.note_request(r);
      if (r.req_type == REQ_ADD) begin
         recent_adds.push_back(r);
         if (recent_adds.size() > 24) void'(recent_adds.pop_front());
      end
   endtask

   // Drops valid between bursts for a gap whose length the caller gives.
   task automatic idle_gap(int unsigned n);
      req_chan.valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   // Waits until all expected results are back, plus enough cycles for the
   // block to settle, so the budget register can be written safely.
   task automatic drain();
      int unsigned guard;
      guard = 0;
      req_chan.valid <= 0;
      while (tile_model.pending.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   function automatic tcl_req_type make_request(int unsigned map_range);
      tcl_req_type r;
      int unsigned pick;
      tcl_req_type base;
      r.req_type = REQ_ADD;
      pick = $urandom_range(0, 99);
      r.map_id = 8'($urandom_range(0, map_range));
      r.tile_x = 16'($urandom);
      r.tile_y = 16'($urandom);
      r.tile_width = 13'($urandom_range(0, 64));
      r.tile_height = 13'($urandom_range(0, 64));
      if ($urandom_range(0, 19) == 0) r.tile_width = 13'($urandom_range(0, 4096));
      if ($urandom_range(0, 19) == 0) r.tile_height = 13'($urandom_range(0, 4096));
      r.pixel_bits = 6'($urandom_range(0, 32));
      r.buffer_handle = $urandom;
      if (pick < 45) r.req_type = REQ_ADD;
      else if (pick < 93) begin
         r.req_type = REQ_GET;
         // Most gets are carved out of a known tile so that they can hit.
         if (recent_adds.size() > 0 && $urandom_range(0, 3) != 0) begin
            base = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
            r.map_id = base.map_id;
            r.tile_width = 13'($urandom_range(0, base.tile_width));
            r.tile_height = 13'($urandom_range(0, base.tile_height));
            r.tile_x = base.tile_x + 16'($urandom_range(0, base.tile_width - r.tile_width));
            r.tile_y = base.tile_y + 16'($urandom_range(0, base.tile_height - r.tile_height));
            r.pixel_bits = $urandom_range(0, 1) ? 6'd0 : base.pixel_bits;
         end
      end else if (pick < 97) r.req_type = REQ_PURGE;
      else r.req_type = 2'd3;   // unknown request type
      return r;
   endfunction

   function automatic tcl_req_type directed(logic [1:0] kind, logic [7:0] m,
                                            logic [15:0] x, logic [15:0] y,
                                            logic [12:0] w, logic [12:0] h,
                                            logic [5:0] b, logic [31:0] hd);
      return '{kind, m, x, y, w, h, b, hd};
   endfunction

   initial begin
      tcl_req_type r;
      int unsigned sent, burst;
      logic [31:0] budgets[5];
      budgets = '{32'd0, 32'd2000, 32'd20000, 32'd300000, 32'hFFFF_FFFF};

      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // A zero budget refuses every add; everything else still answers.
      send_request(directed(REQ_ADD, 8'd1, 0, 0, 0, 0, 0, 0));
      send_request(directed(REQ_GET, 8'd1, 0, 0, 0, 0, 0, 0));
      drain();
      write_budget(32'hFFFF_FFFF);

      // Field extremes, hits, misses, any-depth get and zero-size rectangles.
      send_request(directed(REQ_ADD, 8'd255, 16'hFFFF, 16'hFFFF, 13'd4096, 13'd4096,
                            6'd32, 32'hFFFF_FFFF));
      send_request(directed(REQ_ADD, 8'd0, 0, 0, 0, 0, 0, 32'h0));
      send_request(directed(REQ_ADD, 8'd7, 16'd100, 16'd200, 13'd50, 13'd60, 6'd16,
                            32'hA5A5_5A5A));
      send_request(directed(REQ_GET, 8'd7, 16'd110, 16'd210, 13'd40, 13'd50, 6'd0, 0));
      send_request(directed(REQ_GET, 8'd7, 16'd110, 16'd210, 13'd40, 13'd50, 6'd8, 0));
      send_request(directed(REQ_GET, 8'd7, 16'd100, 16'd200, 13'd51, 13'd60, 6'd16, 0));
      send_request(directed(REQ_GET, 8'd0, 0, 0, 0, 0, 0, 0));
      send_request(directed(REQ_GET, 8'd255, 16'hFFFF, 16'hFFFF, 13'd4096, 13'd4096,
                            6'd32, 0));
      send_request(directed(REQ_GET, 8'd255, 16'hFFFF, 16'hFFFF, 0, 0, 6'd63, 0));
      send_request(directed(2'd3, 8'hFF, 16'hFFFF, 16'hFFFF, 13'h1FFF, 13'h1FFF, 6'h3F,
                            32'hFFFF_FFFF));
      // Fill every slot so the least recent entry has to make room.
      for (int i = 0; i < 18; i++)
         send_request(directed(REQ_ADD, 8'(i), 16'(i), 0, 13'd8, 13'd8, 6'd8, i));
      send_request(directed(REQ_PURGE, 0, 0, 0, 0, 0, 0, 0));
      drain();

      // Tight budget: a tile bigger than the budget, then evictions to fit.
      write_budget(32'd1000);
      send_request(directed(REQ_ADD, 8'd2, 0, 0, 13'd100, 13'd100, 6'd8, 1));
      for (int i = 0; i < 6; i++)
         send_request(directed(REQ_ADD, 8'd2, 16'(i * 10), 0, 13'd10, 13'd10, 6'd24, i));
      drain();
      // Lowering the budget below use evicts only at the next add.
      write_budget(32'd200);
      send_request(directed(REQ_GET, 8'd2, 16'd50, 0, 13'd10, 13'd10, 6'd0, 0));
      send_request(directed(REQ_ADD, 8'd2, 0, 0, 13'd4, 13'd4, 6'd8, 9));
      drain();

      // Random phases at several budgets, including both extremes.
      sent = 0;
      for (int phase = 0; phase < 10; phase++) begin
         write_budget(budgets[phase % 5]);
         stall_pattern_on = (phase % 3 != 2);
         if (phase == 3) hold_cycles = 400;   // long receiver stall while requests keep coming
         for (int k = 0; k < 50; k++) begin
            burst = $urandom_range(0, 3);
            r = make_request(phase < 5 ? 3 : 255);
            send_request(r);
            sent++;
            if (burst == 0 && hold_cycles == 0) idle_gap($urandom_range(1, 30));
            else if (burst == 1) idle_gap(1);
         end
         drain();   // the sender waits for every expected result here
      end

      if (tile_model.errors == 0 && tile_model.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
